@@ rtl/core/wsse_pkg.sv @@
package wsse_pkg;

    typedef enum logic [2:0] {
        PH_RIFF = 3'd0,
        PH_HDR  = 3'd1,
        PH_FMT  = 3'd2,
        PH_DATA = 3'd3,
        PH_SKIP = 3'd4,
        PH_PAD  = 3'd5,
        PH_DEAD = 3'd6
    } phase_t;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_BAD_HDR   = 4'd1;
    localparam logic [3:0] ST_TOO_LARGE = 4'd2;
    localparam logic [3:0] ST_TRUNC     = 4'd3;
    localparam logic [3:0] ST_BAD_FMT   = 4'd4;
    localparam logic [3:0] ST_MISSING   = 4'd5;
    localparam logic [3:0] ST_BAD_CHAN  = 4'd6;
    localparam logic [3:0] ST_BAD_BITS  = 4'd7;
    localparam logic [3:0] ST_ORDER     = 4'd8;

    localparam logic [1:0] FK_NONE  = 2'd0;
    localparam logic [1:0] FK_PCM   = 2'd1;
    localparam logic [1:0] FK_FLOAT = 2'd2;
    localparam logic [1:0] FK_EXT   = 2'd3;

    localparam logic [2:0] SEEN_FMT  = 3'b001;
    localparam logic [2:0] SEEN_DATA = 3'b010;
    localparam logic [2:0] SEEN_RIFF = 3'b100;

    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;

    localparam logic [15:0] FMT_TAG_PCM   = 16'h0001;
    localparam logic [15:0] FMT_TAG_FLOAT = 16'h0003;
    localparam logic [15:0] FMT_TAG_EXT   = 16'hFFFE;

    localparam logic       KIND_SAMPLE = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    localparam int QDEPTH = 8;
    localparam int QAW    = 3;
    localparam logic [QAW:0] QSTALL = 4'd4;

    typedef struct packed {
        logic        kind;
        logic [31:0] sample_value;
        logic [3:0]  status_code;
        logic [31:0] rate_hz;
        logic        run_end;
    } res_t;

endpackage

@@ rtl/core/wav_stream_sample_extractor_core.sv @@
// RIFF/WAVE stream parser. Takes one file byte per beat on the input channel
// and returns decoded first-channel samples (signed Q1.31) and, on the byte
// flagged end_of_file, a final status beat with an error code and the sample
// rate; that status always carries run_end and the parser then starts over
// for the next file. Each accepted byte passes through one input register,
// where a single combinational pass updates the parse state and decodes the
// sample (PCM or float, truncated and saturated), and then into an 8-entry
// result queue. The block sustains one byte per cycle while in_stall is low,
// and results are shown from the queue registers. One byte can yield two
// results (the last sample and the status), so in_stall rises while the queue
// holds over four entries; the output drains one beat a cycle unless out_stall.
module wav_stream_sample_extractor_core #(
    parameter int unsigned MAX_FILE_BYTES = 67108864
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          file_byte,
    input  logic                end_of_file,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                kind,
    output logic signed [31:0]  sample_value,
    output logic [3:0]          status_code,
    output logic [31:0]         rate_hz,
    output logic                run_end
);
    import wsse_pkg::*;

    localparam int POS_W = $clog2(MAX_FILE_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FILE_BYTES);
    localparam logic [31:0] SIZE_MAX = 32'(MAX_FILE_BYTES);

    // Saturated Q1.31 result and sign application.
    function automatic logic [31:0] q31(input logic neg, input logic big,
                                        input logic [31:0] mag);
        if (big)
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return neg ? (32'd0 - mag) : mag;
    endfunction

    function automatic logic [31:0] from_f32(input logic [31:0] u);
        logic [7:0]  ex;
        logic [31:0] m;
        logic [7:0]  sh;
        ex = u[30:23];
        m  = {9'd0, u[22:0]};
        if (ex == 8'hFF)
            return (m != 32'd0) ? 32'd0 : q31(u[31], 1'b1, 32'd0);
        if (ex == 8'd0)
            ex = 8'd1;
        else
            m[23] = 1'b1;
        if (ex >= 8'd127)
            return q31(u[31], 1'b1, 32'd0);
        if (ex >= 8'd119) begin
            sh = ex - 8'd119;
            return q31(u[31], 1'b0, m << sh[2:0]);
        end
        sh = 8'd119 - ex;
        return q31(u[31], 1'b0, (sh >= 8'd32) ? 32'd0 : (m >> sh[4:0]));
    endfunction

    function automatic logic [31:0] from_f64(input logic [63:0] u);
        logic [10:0] ex;
        logic [63:0] m;
        logic [10:0] r;
        logic [63:0] mag;
        ex = u[62:52];
        m  = {12'd0, u[51:0]};
        if (ex == 11'h7FF)
            return (m != 64'd0) ? 32'd0 : q31(u[63], 1'b1, 32'd0);
        if (ex == 11'd0)
            ex = 11'd1;
        else
            m[52] = 1'b1;
        if (ex >= 11'd1023)
            return q31(u[63], 1'b1, 32'd0);
        r   = 11'd1044 - ex;
        mag = (r >= 11'd64) ? 64'd0 : (m >> r[5:0]);
        return q31(u[63], 1'b0, mag[31:0]);
    endfunction

    function automatic logic [31:0] decode(input logic [1:0] fk, input logic [15:0] bits,
                                           input logic [63:0] sh);
        if (fk == FK_FLOAT)
            return (bits == 16'd32) ? from_f32(sh[31:0]) : from_f64(sh);
        case (bits)
            16'd8:   return {sh[7:0] ^ 8'h80, 24'd0};
            16'd16:  return {sh[15:0], 16'd0};
            16'd24:  return {sh[23:0], 8'd0};
            default: return sh[31:0];
        endcase
    endfunction

    function automatic logic [3:0] first_err(input logic [3:0] cur, input logic [3:0] code);
        return (cur == ST_OK) ? code : cur;
    endfunction

    // Input register
    logic       vld_reg, vld_next;
    logic [7:0] byte_reg;
    logic       eof_reg;

    // Parse state
    logic [POS_W-1:0] pos_reg, pos_next;
    phase_t      ph_reg, ph_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] rem_reg, rem_next;
    logic        odd_reg, odd_next;
    logic [1:0]  fk_reg, fk_next;
    logic [15:0] chn_reg, chn_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [5:0]  fbi_reg, fbi_next;
    logic [63:0] shift_reg, shift_next;
    logic [2:0]  seen_reg, seen_next;
    logic [3:0]  err_reg, err_next;

    logic        got;
    logic [31:0] val;
    logic [3:0]  code;

    // Result queue
    res_t           q_reg [QDEPTH];
    logic [QAW-1:0] wptr_reg, rptr_reg;
    logic [QAW:0]   cnt_reg;
    logic           push0, push1, pop;
    res_t           ent0, ent1;

    assign in_stall = (cnt_reg > QSTALL);
    assign vld_next = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (vld_next)
        begin
            byte_reg <= file_byte;
            eof_reg  <= end_of_file;
        end
    end

    // One pass of the byte parser over the registered byte.
    always_comb
    begin
        logic [31:0] size;
        logic [15:0] v;
        logic        stop;
        logic [3:0]  bps;
        logic [7:0]  align;
        logic [6:0]  i;

        pos_next   = pos_reg;
        ph_next    = ph_reg;
        tag_next   = tag_reg;
        rem_next   = rem_reg;
        odd_next   = odd_reg;
        fk_next    = fk_reg;
        chn_next   = chn_reg;
        rate_next  = rate_reg;
        bits_next  = bits_reg;
        fbi_next   = fbi_reg;
        shift_next = shift_reg;
        seen_next  = seen_reg;
        err_next   = err_reg;
        got        = 1'b0;
        val        = 32'd0;
        code       = ST_OK;
        size       = 32'd0;
        v          = 16'd0;
        stop       = 1'b0;
        bps        = 4'd0;
        align      = 8'd0;
        i          = 7'd0;

        if (vld_reg)
        begin
            if (pos_reg >= POS_MAX)
            begin
                if (ph_next != PH_DEAD)
                begin
                    err_next = first_err(err_next, ST_TOO_LARGE);
                    ph_next  = PH_DEAD;
                end
            end
            else
                pos_next = pos_reg + 1'b1;

            case (ph_next)
                PH_RIFF:
                begin
                    if (pos_reg < POS_W'(4) &&
                        byte_reg != TAG_RIFF[8*pos_reg[1:0] +: 8])
                    begin
                        err_next = first_err(err_next, ST_BAD_HDR);
                        ph_next  = PH_DEAD;
                    end
                    else if (pos_reg >= POS_W'(8) && pos_reg < POS_W'(12) &&
                             byte_reg != TAG_WAVE[8*pos_reg[1:0] +: 8])
                    begin
                        err_next = first_err(err_next, ST_BAD_HDR);
                        ph_next  = PH_DEAD;
                    end
                    else if (pos_reg >= POS_W'(11))
                    begin
                        ph_next   = PH_HDR;
                        seen_next = seen_next | SEEN_RIFF;
                        fbi_next  = 6'd0;
                    end
                end
                PH_HDR:
                begin
                    if (fbi_next < 6'd4)
                    begin
                        if (fbi_next == 6'd0)
                            tag_next = 32'd0;
                        tag_next = tag_next | ({24'd0, byte_reg} << (8 * fbi_next[1:0]));
                    end
                    else
                    begin
                        if (fbi_next == 6'd4)
                            rem_next = 32'd0;
                        rem_next = rem_next | ({24'd0, byte_reg} << (8 * fbi_next[1:0]));
                    end
                    fbi_next = fbi_next + 6'd1;
                    if (fbi_next >= 6'd8)
                    begin
                        // Header complete: dispatch on the tag.
                        fbi_next = 6'd0;
                        size     = rem_next;
                        odd_next = size[0];
                        if (size > SIZE_MAX)
                        begin
                            err_next = first_err(err_next, ST_TOO_LARGE);
                            ph_next  = PH_DEAD;
                        end
                        else if (tag_next == TAG_FMT)
                        begin
                            if ((seen_next & SEEN_DATA) != 3'd0)
                            begin
                                err_next = first_err(err_next, ST_ORDER);
                                ph_next  = PH_DEAD;
                            end
                            else if (size < 32'd16)
                            begin
                                err_next = first_err(err_next, ST_BAD_FMT);
                                ph_next  = PH_DEAD;
                            end
                            else
                            begin
                                fk_next = FK_NONE;
                                ph_next = PH_FMT;
                            end
                        end
                        else if (tag_next == TAG_DATA)
                        begin
                            if ((seen_next & SEEN_FMT) == 3'd0 ||
                                (seen_next & SEEN_DATA) != 3'd0)
                            begin
                                err_next = first_err(err_next, ST_ORDER);
                                ph_next  = PH_DEAD;
                            end
                            else if (chn_next < 16'd1 || chn_next > 16'd8)
                            begin
                                err_next = first_err(err_next, ST_BAD_CHAN);
                                ph_next  = PH_DEAD;
                            end
                            else if (!((fk_next == FK_FLOAT &&
                                        (bits_next == 16'd32 || bits_next == 16'd64)) ||
                                       (fk_next == FK_PCM &&
                                        (bits_next == 16'd8 || bits_next == 16'd16 ||
                                         bits_next == 16'd24 || bits_next == 16'd32))))
                            begin
                                err_next = first_err(err_next, ST_BAD_BITS);
                                ph_next  = PH_DEAD;
                            end
                            else
                            begin
                                seen_next = seen_next | SEEN_DATA;
                                if (size == 32'd0)
                                begin
                                    ph_next    = odd_next ? PH_PAD : PH_HDR;
                                    fbi_next   = 6'd0;
                                    shift_next = 64'd0;
                                end
                                else
                                    ph_next = PH_DATA;
                            end
                        end
                        else if (size == 32'd0)
                        begin
                            ph_next    = odd_next ? PH_PAD : PH_HDR;
                            fbi_next   = 6'd0;
                            shift_next = 64'd0;
                        end
                        else
                            ph_next = PH_SKIP;
                    end
                end
                PH_FMT:
                begin
                    v = {byte_reg, shift_next[7:0]};
                    case (fbi_next)
                        6'd0: shift_next = {56'd0, byte_reg};
                        6'd1:
                        begin
                            if (v == FMT_TAG_EXT)
                            begin
                                if (rem_next < 32'd39)
                                    stop = 1'b1;
                                else
                                    fk_next = FK_EXT;
                            end
                            else if (v == FMT_TAG_PCM)
                                fk_next = FK_PCM;
                            else if (v == FMT_TAG_FLOAT)
                                fk_next = FK_FLOAT;
                            else
                                stop = 1'b1;
                        end
                        6'd2: chn_next = {8'd0, byte_reg};
                        6'd3: chn_next = {byte_reg, chn_next[7:0]};
                        6'd4: rate_next = {24'd0, byte_reg};
                        6'd5, 6'd6, 6'd7:
                            rate_next = rate_next | ({24'd0, byte_reg} << (8 * fbi_next[1:0]));
                        6'd14: bits_next = {8'd0, byte_reg};
                        6'd15: bits_next = {byte_reg, bits_next[7:0]};
                        6'd24:
                        begin
                            if (fk_next == FK_EXT)
                                shift_next = {56'd0, byte_reg};
                        end
                        6'd25:
                        begin
                            if (fk_next == FK_EXT)
                            begin
                                if (v == FMT_TAG_PCM)
                                    fk_next = FK_PCM;
                                else if (v == FMT_TAG_FLOAT)
                                    fk_next = FK_FLOAT;
                                else
                                    stop = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    if (stop)
                    begin
                        err_next = first_err(err_next, ST_BAD_FMT);
                        ph_next  = PH_DEAD;
                    end
                    else
                    begin
                        if (fbi_next < 6'd63)
                            fbi_next = fbi_next + 6'd1;
                        rem_next = rem_next - 32'd1;
                        if (rem_next == 32'd0)
                        begin
                            seen_next  = seen_next | SEEN_FMT;
                            ph_next    = odd_next ? PH_PAD : PH_HDR;
                            fbi_next   = 6'd0;
                            shift_next = 64'd0;
                        end
                    end
                end
                PH_DATA:
                begin
                    // Format is checked, so channels <= 8 and bytes per sample <= 8.
                    bps   = bits_next[6:3];
                    align = 8'(chn_next[3:0]) * 8'(bps);
                    if ({1'b0, fbi_next} < {3'd0, bps} && fbi_next < 6'd8)
                        shift_next = shift_next | ({56'd0, byte_reg} << (8 * fbi_next[2:0]));
                    i = {1'b0, fbi_next} + 7'd1;
                    if ({1'b0, i} >= align)
                    begin
                        val        = decode(fk_next, bits_next, shift_next);
                        got        = 1'b1;
                        i          = 7'd0;
                        shift_next = 64'd0;
                    end
                    fbi_next = i[5:0];
                    rem_next = rem_next - 32'd1;
                    if (rem_next == 32'd0)
                    begin
                        ph_next    = odd_next ? PH_PAD : PH_HDR;
                        fbi_next   = 6'd0;
                        shift_next = 64'd0;
                    end
                end
                PH_SKIP:
                begin
                    rem_next = rem_next - 32'd1;
                    if (rem_next == 32'd0)
                    begin
                        ph_next    = odd_next ? PH_PAD : PH_HDR;
                        fbi_next   = 6'd0;
                        shift_next = 64'd0;
                    end
                end
                PH_PAD:
                begin
                    ph_next  = PH_HDR;
                    fbi_next = 6'd0;
                end
                default: ;
            endcase

            if (eof_reg)
            begin
                if (err_next != ST_OK)
                    code = err_next;
                else if (ph_next == PH_RIFF)
                    code = ST_BAD_HDR;
                else if (ph_next == PH_FMT || ph_next == PH_DATA || ph_next == PH_SKIP)
                    code = ST_TRUNC;
                else if ((seen_next & (SEEN_FMT | SEEN_DATA)) != (SEEN_FMT | SEEN_DATA))
                    code = ST_MISSING;
                else
                    code = ST_OK;
            end
        end
    end

    // Status beat takes the rate before the end-of-file restart.
    always_comb
    begin
        ent0 = '0;
        ent1 = '0;
        ent0.kind         = got ? KIND_SAMPLE : KIND_STATUS;
        ent0.sample_value = got ? val : 32'd0;
        ent0.status_code  = got ? ST_OK : code;
        ent0.rate_hz      = got ? 32'd0 : rate_next;
        ent0.run_end      = got ? !eof_reg : 1'b1;
        ent1.kind         = KIND_STATUS;
        ent1.status_code  = code;
        ent1.rate_hz      = rate_next;
        ent1.run_end      = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            ph_reg    <= PH_RIFF;
            tag_reg   <= '0;
            rem_reg   <= '0;
            odd_reg   <= 1'b0;
            fk_reg    <= FK_NONE;
            chn_reg   <= '0;
            rate_reg  <= '0;
            bits_reg  <= '0;
            fbi_reg   <= '0;
            shift_reg <= '0;
            seen_reg  <= '0;
            err_reg   <= ST_OK;
        end
        else if (vld_reg && eof_reg)
        begin
            // Restart for the next file.
            pos_reg   <= '0;
            ph_reg    <= PH_RIFF;
            tag_reg   <= '0;
            rem_reg   <= '0;
            odd_reg   <= 1'b0;
            fk_reg    <= FK_NONE;
            chn_reg   <= '0;
            rate_reg  <= '0;
            bits_reg  <= '0;
            fbi_reg   <= '0;
            shift_reg <= '0;
            seen_reg  <= '0;
            err_reg   <= ST_OK;
        end
        else
        begin
            pos_reg   <= pos_next;
            ph_reg    <= ph_next;
            tag_reg   <= tag_next;
            rem_reg   <= rem_next;
            odd_reg   <= odd_next;
            fk_reg    <= fk_next;
            chn_reg   <= chn_next;
            rate_reg  <= rate_next;
            bits_reg  <= bits_next;
            fbi_reg   <= fbi_next;
            shift_reg <= shift_next;
            seen_reg  <= seen_next;
            err_reg   <= err_next;
        end
    end

    // Result queue: up to two pushes, one pop per cycle.
    assign push0 = vld_reg && (got || eof_reg);
    assign push1 = vld_reg && got && eof_reg;
    assign out_valid = (cnt_reg != '0);
    assign pop = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (push0)
            q_reg[wptr_reg] <= ent0;
        if (push1)
            q_reg[wptr_reg + 1'b1] <= ent1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_reg + QAW'(push0) + QAW'(push1);
            rptr_reg <= rptr_reg + QAW'(pop);
            cnt_reg  <= cnt_reg + (QAW+1)'(push0) + (QAW+1)'(push1) - (QAW+1)'(pop);
        end
    end

    assign kind         = q_reg[rptr_reg].kind;
    assign sample_value = q_reg[rptr_reg].sample_value;
    assign status_code  = q_reg[rptr_reg].status_code;
    assign rate_hz      = q_reg[rptr_reg].rate_hz;
    assign run_end      = q_reg[rptr_reg].run_end;

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QAW+1)'(QDEPTH))
        else $error("result queue overflow");

    a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_STATUS |-> run_end)
        else $error("status beat without run_end");

    a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg && eof_reg |=> ph_reg == PH_RIFF && pos_reg == '0 && err_reg == ST_OK)
        else $error("parser did not restart after end of file");
`endif

endmodule

@@ test/wav_stream_sample_extractor_core_tb.sv @@
`timescale 1ns / 1ps

module wav_stream_sample_extractor_core_tb;
    import wsse_pkg::*;

    localparam int unsigned FILE_LIMIT = 67108864;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          NUM_ITEMS = 1050;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         file_byte;
    logic               end_of_file;
    logic               out_valid;
    logic               out_stall;
    logic               kind;
    logic signed [31:0] sample_value;
    logic [3:0]         status_code;
    logic [31:0]        rate_hz;
    logic               run_end;

    wav_stream_sample_extractor_core #(
        .MAX_FILE_BYTES(FILE_LIMIT)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .file_byte(file_byte),
        .end_of_file(end_of_file),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .sample_value(sample_value),
        .status_code(status_code),
        .rate_hz(rate_hz),
        .run_end(run_end)
    );

    // 12 ns clock: 6 high, 6 low
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Parser mirror: state of the file being walked, updated per byte beat
    // ------------------------------------------------------------------
    logic [26:0] pos_count;
    phase_t      walk_phase;
    logic [31:0] cur_tag;
    logic [31:0] body_left;
    logic        body_odd;
    logic [1:0]  fmt_type;
    logic [15:0] num_chan;
    logic [31:0] rate_seen;
    logic [15:0] bits_per;
    logic [5:0]  sub_idx;
    logic [63:0] byte_acc;
    logic [2:0]  seen_mask;
    logic [3:0]  first_err;

    res_t expected_beats[$];

    int  error_count = 0;
    int  files_sent = 0;
    int  bytes_sent = 0;
    int  samples_seen = 0;
    int  status_seen = 0;
    int  cycle_count = 0;
    int  tx_idle_pct = 26;
    int  rx_idle_pct = 74;
    bit  hold_wanted = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;

    function automatic void clear_parser();
        pos_count  = '0;
        walk_phase = PH_RIFF;
        cur_tag    = '0;
        body_left  = '0;
        body_odd   = 1'b0;
        fmt_type   = FK_NONE;
        num_chan   = '0;
        rate_seen  = '0;
        bits_per   = '0;
        sub_idx    = '0;
        byte_acc   = '0;
        seen_mask  = '0;
        first_err  = ST_OK;
    endfunction

    // Latch the first error only; the walk goes dead until end of file.
    function automatic void latch_error(logic [3:0] code);
        if (first_err == ST_OK)
            first_err = code;
        walk_phase = PH_DEAD;
    endfunction

    function automatic void end_body();
        walk_phase = body_odd ? PH_PAD : PH_HDR;
        sub_idx    = '0;
        byte_acc   = '0;
    endfunction

    function automatic bit bits_supported();
        if (fmt_type == FK_FLOAT)
            return bits_per == 16'd32 || bits_per == 16'd64;
        if (fmt_type == FK_PCM)
            return bits_per == 16'd8 || bits_per == 16'd16 ||
                   bits_per == 16'd24 || bits_per == 16'd32;
        return 1'b0;
    endfunction

    // Dispatch on the chunk tag once all 8 header bytes are in.
    function automatic void open_chunk();
        body_odd = body_left[0];
        if (body_left > FILE_LIMIT)
            latch_error(ST_TOO_LARGE);
        else if (cur_tag == TAG_FMT)
        begin
            if ((seen_mask & SEEN_DATA) != 0)
                latch_error(ST_ORDER);
            else if (body_left < 16)
                latch_error(ST_BAD_FMT);
            else
            begin
                fmt_type   = FK_NONE;
                walk_phase = PH_FMT;
            end
        end
        else if (cur_tag == TAG_DATA)
        begin
            if ((seen_mask & SEEN_FMT) == 0 || (seen_mask & SEEN_DATA) != 0)
                latch_error(ST_ORDER);
            else if (num_chan < 1 || num_chan > 8)
                latch_error(ST_BAD_CHAN);
            else if (!bits_supported())
                latch_error(ST_BAD_BITS);
            else
            begin
                seen_mask |= SEEN_DATA;
                if (body_left == 0)
                    end_body();
                else
                    walk_phase = PH_DATA;
            end
        end
        else if (body_left == 0)
            end_body();
        else
            walk_phase = PH_SKIP;
    endfunction

    function automatic logic [31:0] to_q31(bit neg, bit sat, logic [63:0] mag);
        if (sat)
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return neg ? (32'd0 - mag[31:0]) : mag[31:0];
    endfunction

    function automatic logic [31:0] single_to_q31(logic [31:0] u);
        int unsigned ex;
        logic [63:0] m;
        ex = u[30:23];
        m  = {41'd0, u[22:0]};
        if (ex == 255)
            return (m != 0) ? 32'd0 : to_q31(u[31], 1'b1, 64'd0);
        if (ex == 0)
            ex = 1;
        else
            m[23] = 1'b1;
        if (ex >= 127)
            return to_q31(u[31], 1'b1, 64'd0);
        if (ex >= 119)
            return to_q31(u[31], 1'b0, m << (ex - 119));
        return to_q31(u[31], 1'b0, ((119 - ex) >= 64) ? 64'd0 : m >> (119 - ex));
    endfunction

    function automatic logic [31:0] double_to_q31(logic [63:0] u);
        int unsigned ex;
        int unsigned sh;
        logic [63:0] m;
        ex = u[62:52];
        m  = {12'd0, u[51:0]};
        if (ex == 2047)
            return (m != 0) ? 32'd0 : to_q31(u[63], 1'b1, 64'd0);
        if (ex == 0)
            ex = 1;
        else
            m[52] = 1'b1;
        if (ex >= 1023)
            return to_q31(u[63], 1'b1, 64'd0);
        sh = 1044 - ex;
        return to_q31(u[63], 1'b0, (sh >= 64) ? 64'd0 : m >> sh);
    endfunction

    function automatic logic [31:0] frame_sample();
        if (fmt_type == FK_FLOAT)
            return (bits_per == 16'd32) ? single_to_q31(byte_acc[31:0])
                                        : double_to_q31(byte_acc);
        case (bits_per)
            16'd8:   return {byte_acc[7:0] ^ 8'h80, 24'd0};
            16'd16:  return {byte_acc[15:0], 16'd0};
            16'd24:  return {byte_acc[23:0], 8'd0};
            default: return byte_acc[31:0];
        endcase
    endfunction

    // Stops early, with the walk dead, when the fmt body is rejected.
    function automatic void take_fmt_byte(logic [7:0] b);
        logic [15:0] v;
        v = {b, byte_acc[7:0]};
        case (sub_idx)
            6'd0: byte_acc = {56'd0, b};
            6'd1:
            begin
                if (v == FMT_TAG_EXT)
                begin
                    if (body_left < 39)
                    begin
                        latch_error(ST_BAD_FMT);
                        return;
                    end
                    fmt_type = FK_EXT;
                end
                else if (v == FMT_TAG_PCM)
                    fmt_type = FK_PCM;
                else if (v == FMT_TAG_FLOAT)
                    fmt_type = FK_FLOAT;
                else
                begin
                    latch_error(ST_BAD_FMT);
                    return;
                end
            end
            6'd2: num_chan = {8'd0, b};
            6'd3: num_chan[15:8] = b;
            6'd4: rate_seen = {24'd0, b};
            6'd5: rate_seen[15:8] = b;
            6'd6: rate_seen[23:16] = b;
            6'd7: rate_seen[31:24] = b;
            6'd14: bits_per = {8'd0, b};
            6'd15: bits_per[15:8] = b;
            6'd24: if (fmt_type == FK_EXT) byte_acc = {56'd0, b};
            6'd25:
            begin
                if (fmt_type == FK_EXT)
                begin
                    if (v == FMT_TAG_PCM)
                        fmt_type = FK_PCM;
                    else if (v == FMT_TAG_FLOAT)
                        fmt_type = FK_FLOAT;
                    else
                    begin
                        latch_error(ST_BAD_FMT);
                        return;
                    end
                end
            end
            default: ;
        endcase
        if (sub_idx < 63)
            sub_idx++;
        body_left--;
        if (body_left == 0)
        begin
            seen_mask |= SEEN_FMT;
            end_body();
        end
    endfunction

    // Advance the mirror by one byte and queue the beats it should produce.
    function automatic void predict_byte(logic [7:0] b, logic eof);
        int unsigned pos;
        int unsigned bps;
        int unsigned align;
        int unsigned i;
        bit          got;
        logic [31:0] val;
        res_t        r;
        logic [3:0]  code;
        got = 1'b0;
        val = '0;
        pos = pos_count;
        if (pos >= FILE_LIMIT)
        begin
            if (walk_phase != PH_DEAD)
                latch_error(ST_TOO_LARGE);
        end
        else
            pos_count = 27'(pos + 1);

        case (walk_phase)
            PH_RIFF:
            begin
                if (pos < 4 && b != TAG_RIFF[8*pos +: 8])
                    latch_error(ST_BAD_HDR);
                else if (pos >= 8 && pos < 12 && b != TAG_WAVE[8*(pos-8) +: 8])
                    latch_error(ST_BAD_HDR);
                else if (pos >= 11)
                begin
                    walk_phase = PH_HDR;
                    seen_mask |= SEEN_RIFF;
                    sub_idx    = '0;
                end
            end
            PH_HDR:
            begin
                if (sub_idx < 4)
                begin
                    if (sub_idx == 0)
                        cur_tag = '0;
                    cur_tag[8*sub_idx +: 8] = b;
                end
                else
                begin
                    if (sub_idx == 4)
                        body_left = '0;
                    body_left[8*((sub_idx - 4) & 3) +: 8] = b;
                end
                sub_idx++;
                if (sub_idx >= 8)
                begin
                    sub_idx = '0;
                    open_chunk();
                end
            end
            PH_FMT: take_fmt_byte(b);
            PH_DATA:
            begin
                bps   = bits_per >> 3;
                align = num_chan * bps;
                i     = sub_idx;
                if (i < bps && i < 8)
                    byte_acc[8*i +: 8] = b;
                i++;
                if (i >= align)
                begin
                    val      = frame_sample();
                    got      = 1'b1;
                    i        = 0;
                    byte_acc = '0;
                end
                sub_idx = i[5:0];
                body_left--;
                if (body_left == 0)
                    end_body();
            end
            PH_SKIP:
            begin
                body_left--;
                if (body_left == 0)
                    end_body();
            end
            PH_PAD:
            begin
                walk_phase = PH_HDR;
                sub_idx    = '0;
            end
            default: ;
        endcase

        if (got)
        begin
            r = '{kind: KIND_SAMPLE, sample_value: val, status_code: ST_OK,
                  rate_hz: 32'd0, run_end: !eof};
            expected_beats.push_back(r);
        end
        if (eof)
        begin
            if (first_err != ST_OK)
                code = first_err;
            else if (walk_phase == PH_RIFF)
                code = ST_BAD_HDR;
            else if (walk_phase == PH_FMT || walk_phase == PH_DATA ||
                     walk_phase == PH_SKIP)
                code = ST_TRUNC;
            else if ((seen_mask & (SEEN_FMT | SEEN_DATA)) != (SEEN_FMT | SEEN_DATA))
                code = ST_MISSING;
            else
                code = ST_OK;
            r = '{kind: KIND_STATUS, sample_value: 32'd0, status_code: code,
                  rate_hz: rate_seen, run_end: 1'b1};
            expected_beats.push_back(r);
            clear_parser();
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte source: idles at random, holds the beat until accepted
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eof);
        while (!hold_wanted && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        file_byte   <= b;
        end_of_file <= eof;
        do
            @(posedge clk);
        while (in_stall);
        predict_byte(b, eof);
        bytes_sent++;
        if (eof)
            files_sent++;
    endtask

    // Push one little-endian 32-bit word.
    task automatic put_word(ref logic [7:0] f[$], input logic [31:0] w);
        for (int k = 0; k < 4; k++)
            f.push_back(w[8*k +: 8]);
    endtask

    // Build one data body: whole frames, optionally a partial tail.
    // First-channel float samples get their top byte biased toward the saturation
    // boundary, infinities and NaN so every conversion path is hit.
    task automatic put_frames(ref logic [7:0] f[$], input int frames,
                              input int chans, input int bytes_per, input bit is_float,
                              input int tail);
        logic [7:0] b;
        for (int fr = 0; fr < frames * chans * bytes_per + tail; fr++)
        begin
            b = 8'($urandom_range(255));
            if (is_float && (fr % (chans * bytes_per)) == bytes_per - 1)
                case ($urandom_range(5))
                    0: b = 8'h3F;
                    1: b = 8'hBF;
                    2: b = 8'h7F;
                    3: b = 8'hFF;
                    4: b = {b[7], 7'h3E};
                    default: ;
                endcase
            f.push_back(b);
        end
    endtask

    task automatic build_file(ref logic [7:0] f[$]);
        int          style;
        int          fsize;
        int          ftag;
        int          chans;
        int          bits;
        int          bytes_per;
        int          frames;
        int          tail;
        int          dsize;
        int          junk;
        bit          is_float;
        bit          data_first;
        logic [15:0] sub;
        f.delete();
        style = $urandom_range(99);
        if (style < 7)
        begin
            // noise: random bytes, sometimes behind a good RIFF tag
            if ($urandom_range(1))
                put_word(f, TAG_RIFF);
            repeat ($urandom_range(1, 20))
                f.push_back(8'($urandom_range(255)));
            return;
        end
        put_word(f, TAG_RIFF);
        put_word(f, $urandom);
        put_word(f, TAG_WAVE);

        if ($urandom_range(99) < 30)
        begin
            junk = $urandom_range(5);
            put_word(f, $urandom);
            put_word(f, junk);
            repeat (junk + (junk & 1))
                f.push_back(8'($urandom_range(255)));
        end

        // format choice
        case ($urandom_range(2))
            0: ftag = FMT_TAG_PCM;
            1: ftag = FMT_TAG_FLOAT;
            default: ftag = FMT_TAG_EXT;
        endcase
        sub      = ($urandom_range(1)) ? FMT_TAG_PCM : FMT_TAG_FLOAT;
        is_float = (ftag == FMT_TAG_FLOAT) || (ftag == FMT_TAG_EXT && sub == FMT_TAG_FLOAT);
        if (is_float)
            bits = $urandom_range(1) ? 32 : 64;
        else
            bits = 8 * $urandom_range(1, 4);
        chans = $urandom_range(1, 3);
        if ($urandom_range(99) < 8)
            chans = $urandom_range(99) < 50 ? $urandom_range(0, 10) : $urandom_range(65535);
        if ($urandom_range(99) < 8)
            bits = $urandom_range(99) < 50 ? $urandom_range(0, 72) : $urandom_range(65535);
        if ($urandom_range(99) < 5)
            ftag = $urandom_range(65535);
        if ($urandom_range(99) < 5)
            sub = 16'($urandom_range(65535));
        if (ftag == FMT_TAG_EXT)
            fsize = ($urandom_range(99) < 10) ? $urandom_range(16, 39) : 40;
        else
            fsize = ($urandom_range(99) < 10) ? $urandom_range(12, 19) : 16;
        bytes_per  = bits / 8;
        data_first = ($urandom_range(99) < 5);

        frames = $urandom_range(0, 5);
        tail   = ($urandom_range(99) < 20 && chans * bytes_per > 1) ?
                 $urandom_range(1, chans * bytes_per - 1) : 0;
        if (chans < 1 || chans > 8 || bytes_per < 1 || bytes_per > 8)
            dsize = $urandom_range(0, 12);
        else
            dsize = frames * chans * bytes_per + tail;

        if (data_first)
        begin
            put_word(f, TAG_DATA);
            put_word(f, 4);
            put_word(f, $urandom);
        end

        put_word(f, TAG_FMT);
        put_word(f, fsize);
        f.push_back(ftag[7:0]);
        f.push_back(ftag[15:8]);
        f.push_back(chans[7:0]);
        f.push_back(chans[15:8]);
        put_word(f, $urandom);
        repeat (6)
            f.push_back(8'($urandom_range(255)));
        f.push_back(bits[7:0]);
        f.push_back(bits[15:8]);
        for (int k = 16; k < fsize; k++)
            if (k == 24)
                f.push_back(sub[7:0]);
            else if (k == 25)
                f.push_back(sub[15:8]);
            else
                f.push_back(8'($urandom_range(255)));
        if (fsize & 1)
            f.push_back(8'($urandom_range(255)));

        put_word(f, TAG_DATA);
        if ($urandom_range(99) < 4)
            put_word(f, FILE_LIMIT + $urandom_range(1, 1000));
        else
            put_word(f, dsize);
        if (chans >= 1 && chans <= 8 && bytes_per >= 1 && bytes_per <= 8)
            put_frames(f, frames, chans, bytes_per, is_float, tail);
        else
            repeat (dsize)
                f.push_back(8'($urandom_range(255)));
        if (dsize & 1)
            f.push_back(8'($urandom_range(255)));

        if ($urandom_range(99) < 5)
        begin
            put_word(f, $urandom_range(1) ? TAG_DATA : TAG_FMT);
            put_word(f, 2);
            put_word(f, $urandom);
        end

        // damage: flip one byte or cut the file short
        if ($urandom_range(99) < 10)
            f[$urandom_range(f.size() - 1)] = 8'($urandom_range(255));
        if ($urandom_range(99) < 10)
            f = f[0 : $urandom_range(f.size() - 1)];
    endtask

    // ------------------------------------------------------------------
    // Directed table: short files, status typed in where it is plain
    // ------------------------------------------------------------------
    typedef struct {
        logic [7:0] b;
        logic       eof;
        int         status;   // -1: trust the mirror
    } dir_row_t;

    dir_row_t dir_rows[] = '{
        '{8'h00, 1'b1, ST_BAD_HDR},
        '{8'hFF, 1'b1, ST_BAD_HDR},
        '{8'h52, 1'b0, -1},
        '{8'h58, 1'b1, ST_BAD_HDR},
        '{8'h52, 1'b0, -1},
        '{8'h49, 1'b0, -1},
        '{8'h46, 1'b0, -1},
        '{8'h46, 1'b0, -1},
        '{8'hFF, 1'b0, -1},
        '{8'h00, 1'b0, -1},
        '{8'hAA, 1'b0, -1},
        '{8'h55, 1'b0, -1},
        '{8'h57, 1'b0, -1},
        '{8'h41, 1'b0, -1},
        '{8'h56, 1'b0, -1},
        '{8'h45, 1'b1, ST_MISSING},
        '{8'h52, 1'b0, -1},
        '{8'h49, 1'b0, -1},
        '{8'h46, 1'b0, -1},
        '{8'h46, 1'b1, ST_BAD_HDR}
    };

    // ------------------------------------------------------------------
    // Sink: random stall, plus one long hold-off to back the block up
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_wanted && !hold_done && hold_left == 0)
        begin
            hold_left <= 300;
            hold_done <= 1'b1;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Compare every accepted result beat against the oldest expectation.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("unexpected result beat: kind=%0d value=%h code=%0d",
                       kind, sample_value, status_code);
                error_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (kind == KIND_SAMPLE)
                    samples_seen++;
                else
                    status_seen++;
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    error_count++;
                end
                if (sample_value !== want.sample_value)
                begin
                    $error("sample_value: expected %h, got %h",
                           want.sample_value, sample_value);
                    error_count++;
                end
                if (status_code !== want.status_code)
                begin
                    $error("status_code: expected %0d, got %0d",
                           want.status_code, status_code);
                    error_count++;
                end
                if (rate_hz !== want.rate_hz)
                begin
                    $error("rate_hz: expected %h, got %h", want.rate_hz, rate_hz);
                    error_count++;
                end
                if (run_end !== want.run_end)
                begin
                    $error("run_end: expected %0d, got %0d", want.run_end, run_end);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_count, expected_beats.size());
            $display("wav_stream_sample_extractor_core_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0] file_bytes[$];
        int         drain;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        file_byte   = 8'd0;
        end_of_file = 1'b0;
        clear_parser();
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: override the mirror's status where the row types one in
        foreach (dir_rows[n])
        begin
            send_byte(dir_rows[n].b, dir_rows[n].eof);
            if (dir_rows[n].status >= 0)
                expected_beats[$].status_code = 4'(dir_rows[n].status);
        end

        // random files; idling pattern changes by thirds of the byte budget
        while (bytes_sent < NUM_ITEMS)
        begin
            if (bytes_sent > 2 * NUM_ITEMS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                if (!hold_done)
                    hold_wanted = 1'b1;
            end
            else if (bytes_sent > NUM_ITEMS / 3)
            begin
                tx_idle_pct = 74;
                rx_idle_pct = 26;
            end
            build_file(file_bytes);
            foreach (file_bytes[k])
                send_byte(file_bytes[k], k == file_bytes.size() - 1);
        end
        // drop valid after the last accepted beat
        in_valid <= 1'b0;

        // let the queue drain, then wait quietly for stray beats
        drain = 0;
        while (expected_beats.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20)
            @(posedge clk);
        if (expected_beats.size() != 0)
        begin
            $error("%0d expected beats never arrived", expected_beats.size());
            error_count++;
        end

        $display("covered %0d files / %0d bytes: %0d samples and %0d status beats checked",
                 files_sent, bytes_sent, samples_seen, status_seen);
        if (error_count == 0)
            $display("wav_stream_sample_extractor_core_tb OK");
        else
            $display("wav_stream_sample_extractor_core_tb NOT OK");
        $finish;
    end

endmodule

@@ wav_stream_sample_extractor_core.f @@
rtl/core/wsse_pkg.sv
rtl/core/wav_stream_sample_extractor_core.sv
test/wav_stream_sample_extractor_core_tb.sv
